// ===== hdl/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants of the terminal line discipline
// Flag bit positions, control characters, action and result types.
// ----------------------------------------------------------------------------
package tld_pkg;

  // line store geometry
  localparam int LINE_BYTES = 32;
  localparam int FILL_W     = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W     = $clog2(LINE_BYTES);

  // column counter
  localparam int               COL_W   = 16;
  localparam logic [COL_W-1:0] COL_MAX = '1;

  // action queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [2:0] REG_INPUT  = 3'd0;
  localparam logic [2:0] REG_OUTPUT = 3'd1;
  localparam logic [2:0] REG_LOCAL  = 3'd2;
  localparam logic [2:0] REG_SIGNAL = 3'd3;
  localparam logic [2:0] REG_EDIT   = 3'd4;

  // register reset values
  localparam logic [5:0]  RST_INPUT  = 6'd36;
  localparam logic [5:0]  RST_OUTPUT = 6'd5;
  localparam logic [6:0]  RST_LOCAL  = 7'd127;
  localparam logic [23:0] RST_SIGNAL = 24'h1A1C03;
  localparam logic [31:0] RST_EDIT   = 32'h0004157F;

  // input flag bits
  localparam int IF_NL2CR = 0;
  localparam int IF_IGNCR = 1;
  localparam int IF_CR2NL = 2;
  localparam int IF_LOWER = 3;
  localparam int IF_STRIP = 4;
  localparam int IF_BELL  = 5;

  // output flag bits
  localparam int OF_POST   = 0;
  localparam int OF_UPPER  = 1;
  localparam int OF_NLCRNL = 2;
  localparam int OF_CRNL   = 3;
  localparam int OF_NOCR0  = 4;
  localparam int OF_NLRET  = 5;

  // local flag bits
  localparam int LF_SIG     = 0;
  localparam int LF_CANON   = 1;
  localparam int LF_ECHO    = 2;
  localparam int LF_ECHOE   = 3;
  localparam int LF_ECHOK   = 4;
  localparam int LF_ECHONL  = 5;
  localparam int LF_ECHOCTL = 6;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CTL_FLIP = 8'h40;

  // result kinds
  localparam logic [1:0] KIND_TERM   = 2'd0;
  localparam logic [1:0] KIND_READER = 2'd1;
  localparam logic [1:0] KIND_SIGNAL = 2'd2;

  typedef struct packed {
    logic [5:0]  iflags;
    logic [5:0]  oflags;
    logic [6:0]  lflags;
    logic [23:0] sigc;
    logic [31:0] editc;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_PUT, OP_SIG, OP_ERASE, OP_KILL, OP_EOF, OP_CHAR, OP_RAW
  } op_t;

  typedef enum logic [2:0] {
    EC_NONE, EC_PLAIN, EC_CARET, EC_RUB, EC_KILLRUB
  } echo_t;

  typedef enum logic [2:0] {
    SQ_NONE, SQ_PLAIN, SQ_CARET, SQ_BELL, SQ_RUB1, SQ_RUB2, SQ_READ
  } seq_t;

  typedef enum logic [1:0] {
    TL_NONE, TL_SIG, TL_RAW, TL_SEND
  } tail_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_RDWAIT, BS_ECHO, BS_TAIL, BS_SEND_RD, BS_SEND_EM, BS_FINISH
  } bst_t;

  typedef struct packed {
    op_t        op;
    echo_t      echo;
    logic [7:0] ch;
    logic [1:0] sig;
    logic       eol;
  } act_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       line_end;
  } res_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
  } bk_stat_t;

  function automatic logic is_ctl(logic [7:0] c);
    return (c < CH_SP) || (c == CH_DEL);
  endfunction

endpackage

// ===== hdl/tld_in_if.sv =====
// ----------------------------------------------------------------------------
// tld_in_if: input item channel
// Carries a received or written byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] character;

  modport source(output valid, command, character, input ready);
  modport sink(input valid, command, character, output ready);
endinterface

// ===== hdl/tld_out_if.sv =====
// ----------------------------------------------------------------------------
// tld_out_if: result item channel
// Carries one result with kind, data, line end and last markers.
// ----------------------------------------------------------------------------
interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       line_end;
  logic       last;

  modport source(output valid, kind, data, line_end, last, input ready);
  modport sink(input valid, kind, data, line_end, last, output ready);
endinterface

// ===== hdl/tld_ram.sv =====
// ----------------------------------------------------------------------------
// tld_ram: generic memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tld_front.sv =====
// ----------------------------------------------------------------------------
// tld_front: input mapping, classification and action queue
// Maps received bytes, sorts them into actions and queues them for the back.
// ----------------------------------------------------------------------------
module tld_front (
  input  logic          clk,
  input  logic          rst_n,
  tld_in_if.sink        in_ch,
  input  tld_pkg::cfg_t cfg,
  output logic          act_valid,
  output tld_pkg::act_t act,
  input  logic          act_ready
);
  import tld_pkg::*;

  act_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  act_t              cls;
  logic              drop;
  logic              push;
  logic              pop;

  function automatic echo_t echo_class(logic [7:0] c, cfg_t cf);
    echo_t e;
    e = EC_NONE;
    if (c == CH_NL && cf.lflags[LF_ECHONL] && cf.lflags[LF_CANON]) begin
      e = EC_PLAIN;
    end else if (cf.lflags[LF_ECHO]) begin
      priority if (c == CH_NL || c == CH_TAB) begin
        e = EC_PLAIN;
      end else if (c == cf.editc[7:0] && cf.lflags[LF_ECHOE] && cf.lflags[LF_CANON]) begin
        e = EC_RUB;
      end else if (c == cf.editc[15:8] && cf.lflags[LF_ECHOK] && cf.lflags[LF_CANON]) begin
        e = EC_KILLRUB;
      end else if (is_ctl(c) && cf.lflags[LF_ECHOCTL]) begin
        e = EC_CARET;
      end else begin
        e = EC_PLAIN;
      end
    end
    return e;
  endfunction

  // map the byte and sort it into an action
  always_comb begin
    logic [7:0] c;
    c = in_ch.character;
    if (cfg.iflags[IF_NL2CR] && c == CH_NL) begin
      c = CH_CR;
    end
    drop = cfg.iflags[IF_IGNCR] && c == CH_CR;
    if (cfg.iflags[IF_CR2NL] && c == CH_CR) begin
      c = CH_NL;
    end
    if (cfg.iflags[IF_LOWER] && c >= 8'h41 && c <= 8'h5A) begin
      c = c + CASE_OFS;
    end
    if (cfg.iflags[IF_STRIP]) begin
      c[7] = 1'b0;
    end
    cls.ch   = c;
    cls.sig  = 2'd0;
    cls.eol  = (c == CH_NL) || (c == cfg.editc[31:24]);
    cls.echo = echo_class(c, cfg);
    cls.op   = OP_RAW;
    if (in_ch.command) begin
      drop     = 1'b0;
      cls.ch   = in_ch.character;
      cls.op   = OP_PUT;
      cls.echo = EC_PLAIN;
    end else if (cfg.lflags[LF_SIG] && c == cfg.sigc[7:0]) begin
      cls.op  = OP_SIG;
      cls.sig = 2'd0;
    end else if (cfg.lflags[LF_SIG] && c == cfg.sigc[15:8]) begin
      cls.op  = OP_SIG;
      cls.sig = 2'd1;
    end else if (cfg.lflags[LF_SIG] && c == cfg.sigc[23:16]) begin
      cls.op  = OP_SIG;
      cls.sig = 2'd2;
    end else if (cfg.lflags[LF_CANON]) begin
      priority if (c == cfg.editc[7:0]) begin
        cls.op = OP_ERASE;
      end else if (c == cfg.editc[15:8]) begin
        cls.op = OP_KILL;
      end else if (c == cfg.editc[23:16]) begin
        cls.op = OP_EOF;
      end else begin
        cls.op = OP_CHAR;
      end
    end
  end

  // queue control
  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && !drop;
  assign act_valid   = (cnt_r != '0);
  assign act         = q_r[rd_ptr_r];
  assign pop         = act_valid && act_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued actions
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/tld_back.sv =====
// ----------------------------------------------------------------------------
// tld_back: action sequencer
// Edits the line, echoes, post-processes output and flushes lines to the
// reader through a hold stage and an output register, one action at a time.
// ----------------------------------------------------------------------------
module tld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tld_pkg::cfg_t     cfg,
  input  logic              act_valid,
  input  tld_pkg::act_t     act,
  output logic              act_ready,
  tld_out_if.source         out_ch,
  output tld_pkg::bk_stat_t stat
);
  import tld_pkg::*;

  typedef struct packed {
    logic             emit;
    logic [7:0]       ch;
    logic [COL_W-1:0] col;
  } tp_t;

  bst_t              state_r, state_nxt;
  act_t              act_r, act_nxt;
  seq_t              seq_r, seq_nxt;
  tail_t             tail_r, tail_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              pre_r, pre_nxt;
  logic [FILL_W-1:0] sidx_r, sidx_nxt;
  logic [FILL_W-1:0] len_r, len_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              hold_v_r, hold_v_nxt;
  res_t              hold_r, hold_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [FILL_W-1:0] fill_m1;
  logic              out_free;
  logic              emit_go;
  logic              emit_req;
  res_t              emit_res;

  // one terminal byte through output post-processing
  function automatic tp_t term_step(logic [7:0] c, logic [COL_W-1:0] col, logic [5:0] ofl);
    tp_t        r;
    logic [7:0] b;
    b      = c;
    r.emit = 1'b1;
    if (ofl[OF_POST]) begin
      if (ofl[OF_UPPER] && b >= 8'h61 && b <= 8'h7A) begin
        b = b - CASE_OFS;
      end
      if (ofl[OF_CRNL] && b == CH_CR) begin
        b = CH_NL;
      end
      if (ofl[OF_NOCR0] && b == CH_CR && col == '0) begin
        r.emit = 1'b0;
      end
    end
    if (b == CH_CR || (b == CH_NL && ofl[OF_NLRET])) begin
      r.col = '0;
    end else if (col != COL_MAX) begin
      r.col = col + 1'b1;
    end else begin
      r.col = col;
    end
    r.ch = b;
    return r;
  endfunction

  function automatic logic [2:0] seq_len(seq_t s);
    logic [2:0] n;
    unique case (s)
      SQ_CARET: n = 3'd2;
      SQ_RUB1:  n = 3'd3;
      SQ_RUB2:  n = 3'd6;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(seq_t s, logic [2:0] i, logic [7:0] c);
    logic [7:0] b;
    unique case (s)
      SQ_CARET:         b = (i == 3'd0) ? CH_CARET : (c ^ CTL_FLIP);
      SQ_BELL:          b = CH_BEL;
      SQ_RUB1, SQ_RUB2: b = (i == 3'd1 || i == 3'd4) ? CH_SP : CH_BS;
      default:          b = c;
    endcase
    return b;
  endfunction

  // line store
  assign fill_m1   = fill_r - 1'b1;
  assign ram_raddr = (state_r == BS_IDLE) ? fill_m1[ADDR_W-1:0] : sidx_r[ADDR_W-1:0];

  tld_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r[ADDR_W-1:0]),
    .wdata(act.ch),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free = !out_v_r || out_ch.ready;
  assign emit_go  = !hold_v_r || out_free;

  // sequencer: next state and emissions
  always_comb begin
    seq_t       ech;
    logic [7:0] b;
    logic       pre_need;
    tp_t        tp;

    state_nxt    = state_r;
    act_nxt      = act_r;
    seq_nxt      = seq_r;
    tail_nxt     = tail_r;
    idx_nxt      = idx_r;
    pre_nxt      = pre_r;
    sidx_nxt     = sidx_r;
    len_nxt      = len_r;
    fill_nxt     = fill_r;
    col_nxt      = col_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    act_ready    = 1'b0;
    ram_we       = 1'b0;
    emit_req     = 1'b0;
    emit_res     = '0;

    // echo sequence of the incoming action, rub-outs need the last stored byte
    unique case (act.echo)
      EC_PLAIN:   ech = SQ_PLAIN;
      EC_CARET:   ech = SQ_CARET;
      EC_RUB:     ech = (fill_r != '0) ? SQ_READ : SQ_RUB1;
      EC_KILLRUB: ech = (fill_r != '0) ? SQ_READ : SQ_NONE;
      default:    ech = SQ_NONE;
    endcase

    b        = seq_byte(seq_r, idx_r, act_r.ch);
    pre_need = cfg.oflags[OF_POST] && cfg.oflags[OF_NLCRNL] && b == CH_NL && !pre_r;
    tp       = term_step(pre_need ? CH_CR : b, col_r, cfg.oflags);

    unique case (state_r)
      BS_IDLE: begin
        act_ready = 1'b1;
        if (act_valid) begin
          act_nxt  = act;
          idx_nxt  = '0;
          pre_nxt  = 1'b0;
          sidx_nxt = '0;
          seq_nxt  = SQ_NONE;
          tail_nxt = TL_NONE;
          unique case (act.op)
            OP_PUT: seq_nxt = SQ_PLAIN;
            OP_SIG: begin
              seq_nxt  = ech;
              tail_nxt = TL_SIG;
            end
            OP_ERASE: begin
              if (fill_r != '0) begin
                seq_nxt  = ech;
                fill_nxt = fill_m1;
              end
            end
            OP_KILL: begin
              seq_nxt  = ech;
              fill_nxt = '0;
            end
            OP_EOF: begin
              tail_nxt = TL_SEND;
              len_nxt  = fill_r;
              fill_nxt = '0;
            end
            OP_CHAR: begin
              if (fill_r >= FILL_W'(LINE_BYTES)) begin
                seq_nxt = cfg.iflags[IF_BELL] ? SQ_BELL : SQ_NONE;
                len_nxt = fill_r;
              end else begin
                ram_we   = 1'b1;
                seq_nxt  = ech;
                len_nxt  = fill_r + 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
              if (act.eol) begin
                tail_nxt = TL_SEND;
                fill_nxt = '0;
              end
            end
            OP_RAW: begin
              seq_nxt  = ech;
              tail_nxt = TL_RAW;
            end
            default: ;
          endcase
          if (seq_nxt == SQ_READ) begin
            state_nxt = BS_RDWAIT;
          end else if (seq_nxt == SQ_NONE) begin
            state_nxt = BS_TAIL;
          end else begin
            state_nxt = BS_ECHO;
          end
        end
      end

      BS_RDWAIT: begin
        seq_nxt   = (is_ctl(ram_rdata) && cfg.lflags[LF_ECHOCTL]) ? SQ_RUB2 : SQ_RUB1;
        state_nxt = BS_ECHO;
      end

      BS_ECHO: begin
        if (!tp.emit || emit_go) begin
          if (tp.emit) begin
            emit_req = 1'b1;
            emit_res = '{kind: KIND_TERM, data: tp.ch, line_end: 1'b0};
            col_nxt  = tp.col;
          end
          if (pre_need) begin
            pre_nxt = 1'b1;
          end else begin
            pre_nxt = 1'b0;
            if (idx_r == seq_len(seq_r) - 3'd1) begin
              state_nxt = BS_TAIL;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end

      BS_TAIL: begin
        unique case (tail_r)
          TL_SIG: begin
            if (emit_go) begin
              emit_req  = 1'b1;
              emit_res  = '{kind: KIND_SIGNAL, data: {6'd0, act_r.sig}, line_end: 1'b0};
              state_nxt = BS_FINISH;
            end
          end
          TL_RAW: begin
            if (emit_go) begin
              emit_req  = 1'b1;
              emit_res  = '{kind: KIND_READER, data: act_r.ch, line_end: 1'b0};
              state_nxt = BS_FINISH;
            end
          end
          TL_SEND: state_nxt = (len_r == '0) ? BS_FINISH : BS_SEND_RD;
          default: state_nxt = BS_FINISH;
        endcase
      end

      BS_SEND_RD: state_nxt = BS_SEND_EM;

      BS_SEND_EM: begin
        if (emit_go) begin
          emit_req = 1'b1;
          emit_res = '{kind: KIND_READER, data: ram_rdata,
                       line_end: (sidx_r + 1'b1 == len_r)};
          if (sidx_r + 1'b1 == len_r) begin
            state_nxt = BS_FINISH;
          end else begin
            sidx_nxt  = sidx_r + 1'b1;
            state_nxt = BS_SEND_RD;
          end
        end
      end

      BS_FINISH: begin
        // release the held result as the item's last one
        if (!hold_v_r) begin
          state_nxt = BS_IDLE;
        end else if (out_free) begin
          out_nxt      = hold_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = BS_IDLE;
        end
      end

      default: state_nxt = BS_IDLE;
    endcase

    // advance the hold stage on each new result
    if (emit_req) begin
      if (hold_v_r) begin
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
        out_v_nxt    = 1'b1;
      end
      hold_nxt   = emit_res;
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      fill_r   <= '0;
      col_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      col_r    <= col_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    seq_r      <= seq_nxt;
    tail_r     <= tail_nxt;
    idx_r      <= idx_nxt;
    pre_r      <= pre_nxt;
    sidx_r     <= sidx_nxt;
    len_r      <= len_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // drive the result channel
  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.data     = out_r.data;
  assign out_ch.line_end = out_r.line_end;
  assign out_ch.last     = out_last_r;
  assign stat.fill       = fill_r;

endmodule

// ===== hdl/tty_line_discipline.sv =====
// ----------------------------------------------------------------------------
// tty_line_discipline: terminal line discipline top level
// Configuration registers, classifying front, action queue and sequencer.
// ----------------------------------------------------------------------------
// Results: a result leaves the hold stage when the next one arrives or the
// item ends; rub-outs and line flushes read the line store before they emit,
// and the back sequencer emits at most one result a cycle.
// Reset: registers take their defaults, the line is empty, column is zero;
// the line store itself is not cleared and the block is ready at once.
module tty_line_discipline (
  input  logic        clk,
  input  logic        rst_n,
  tld_in_if.sink      in_ch,
  tld_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tld_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     act_valid;
  act_t     act;
  logic     act_ready;
  bk_stat_t stat;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT:  cfg_nxt.iflags = cfg_wdata[5:0];
        REG_OUTPUT: cfg_nxt.oflags = cfg_wdata[5:0];
        REG_LOCAL:  cfg_nxt.lflags = cfg_wdata[6:0];
        REG_SIGNAL: cfg_nxt.sigc   = cfg_wdata[23:0];
        REG_EDIT:   cfg_nxt.editc  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{iflags: RST_INPUT, oflags: RST_OUTPUT, lflags: RST_LOCAL,
                 sigc: RST_SIGNAL, editc: RST_EDIT};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .act_valid(act_valid),
    .act      (act),
    .act_ready(act_ready)
  );

  tld_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .act_valid(act_valid),
    .act      (act),
    .act_ready(act_ready),
    .out_ch   (out_ch),
    .stat     (stat)
  );

`ifndef NO_ASSERTIONS
  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // line end marks reader bytes only
  a_line_end_reader: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.line_end |-> out_ch.kind == KIND_READER)
    else $error("line end on non-reader result");

  // a signal is always the final result of its item
  a_signal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_SIGNAL |-> out_ch.last)
    else $error("signal result not last");

  // the line never outgrows its store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FILL_W'(LINE_BYTES))
    else $error("line fill beyond store");
`endif

endmodule
